>>> sv/rpls_pkg.sv
// rpls_pkg: shared types and constants of the rgbw pixel serializer
`timescale 1ns / 1ps

package rpls_pkg;

  typedef enum logic [1:0] {
    REQ_SET   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_SHOW  = 2'd2,
    REQ_TICK  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_BUSY      = 2'd2
  } status_e;

  // configuration register indexes
  localparam logic [2:0] CFG_BRIGHTNESS = 3'd0;
  localparam logic [2:0] CFG_ZERO_HIGH  = 3'd1;
  localparam logic [2:0] CFG_ZERO_LOW   = 3'd2;
  localparam logic [2:0] CFG_ONE_HIGH   = 3'd3;
  localparam logic [2:0] CFG_ONE_LOW    = 3'd4;

  localparam logic [6:0] RST_BRIGHTNESS = 7'd15;
  localparam logic [7:0] RST_ZERO_HIGH  = 8'd3;
  localparam logic [7:0] RST_ZERO_LOW   = 8'd9;
  localparam logic [7:0] RST_ONE_HIGH   = 8'd9;
  localparam logic [7:0] RST_ONE_LOW    = 8'd5;

  localparam logic [6:0] PCT_FULL = 7'd100;

  // x/100 == (x*5243)>>19 for every x below 43690
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  typedef struct packed {
    logic [7:0] zero_high;
    logic [7:0] zero_low;
    logic [7:0] one_high;
    logic [7:0] one_low;
  } pulse_cfg_t;

  typedef struct packed {
    status_e status;
    logic    busy;
    logic    level;
  } result_t;

endpackage

>>> sv/rpls_scale.sv
// rpls_scale: brightness scaler (registered multiply, reciprocal divide) feeding pixel writes
`timescale 1ns / 1ps

module rpls_scale import rpls_pkg::*; #(
  parameter int LED_COUNT = 4,
  localparam int IW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          set_i,
  input  logic [6:0]    pct_i,
  input  logic [IW-1:0] idx_i,
  input  logic [7:0]    red_i,
  input  logic [7:0]    green_i,
  input  logic [7:0]    blue_i,
  output logic          wr_vld_o,
  output logic [IW-1:0] wr_idx_o,
  output logic [23:0]   wr_data_o
);

  logic [6:0]    pct_sat;
  logic          vld_q;
  logic [IW-1:0] idx_q;
  logic [14:0]   prod_g_q, prod_r_q, prod_b_q;
  logic [27:0]   full_g, full_r, full_b;

  assign pct_sat = (pct_i > PCT_FULL) ? PCT_FULL : pct_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= set_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (set_i) begin
      idx_q    <= idx_i;
      prod_g_q <= 15'(green_i) * 15'(pct_sat);
      prod_r_q <= 15'(red_i) * 15'(pct_sat);
      prod_b_q <= 15'(blue_i) * 15'(pct_sat);
    end
  end

  // divide by 100 through the reciprocal
  assign full_g = 28'(prod_g_q) * 28'(RECIP_100);
  assign full_r = 28'(prod_r_q) * 28'(RECIP_100);
  assign full_b = 28'(prod_b_q) * 28'(RECIP_100);

  assign wr_vld_o  = vld_q;
  assign wr_idx_o  = idx_q;
  // row layout from the low byte up: green, red, blue
  assign wr_data_o = {full_b[RECIP_SHIFT +: 8], full_r[RECIP_SHIFT +: 8],
                      full_g[RECIP_SHIFT +: 8]};

endmodule

>>> sv/rpls_store.sv
// rpls_store: pixel row memory with valid bits and registered read
`timescale 1ns / 1ps

module rpls_store #(
  parameter int LED_COUNT = 4,
  localparam int IW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clr_i,
  input  logic          wr_vld_i,
  input  logic [IW-1:0] wr_idx_i,
  input  logic [23:0]   wr_data_i,
  input  logic [IW-1:0] rd_addr_i,
  output logic [23:0]   rd_row_o
);

  logic [23:0]          mem [LED_COUNT];
  logic [LED_COUNT-1:0] valid_q, valid_d;
  logic                 we;
  logic [23:0]          rd_q;
  logic                 rd_vld_q;

  // a clear drops the write still in flight from the set before it
  assign we = wr_vld_i && !clr_i;

  always_comb begin
    valid_d = valid_q;
    if (clr_i) begin
      valid_d = '0;
    end else if (we) begin
      valid_d[wr_idx_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      rd_vld_q <= valid_d[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    if (we && (wr_idx_i == rd_addr_i)) begin
      rd_q <= wr_data_i;
    end else begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_row_o = rd_vld_q ? rd_q : 24'h000000;

endmodule

>>> sv/rpls_ser.sv
// rpls_ser: frame serializer state and per-item result
`timescale 1ns / 1ps

module rpls_ser import rpls_pkg::*; #(
  parameter int LED_COUNT = 4,
  localparam int IW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  req_e          req_i,
  input  logic          idx_ok_i,
  input  pulse_cfg_t    pulse_i,
  input  logic [23:0]   row_i,
  output logic [IW-1:0] pix_o,
  output logic [IW-1:0] pix_next_o,
  output result_t       res_o
);

  logic          sending_q, sending_d;
  logic          high_q, high_d;
  logic [7:0]    cnt_q, cnt_d;
  logic [2:0]    bit_q, bit_d;
  logic [1:0]    lane_q, lane_d;
  logic [IW-1:0] pix_q, pix_d;
  logic [7:0]    cur_byte;
  logic          cur_bit;
  logic [7:0]    len_sel, len, cnt_inc;
  status_e       status;

  always_comb begin
    case (lane_q)
      2'd0:    cur_byte = row_i[7:0];
      2'd1:    cur_byte = row_i[15:8];
      2'd2:    cur_byte = row_i[23:16];
      default: cur_byte = 8'h00;  // white byte is always zero
    endcase
  end

  assign cur_bit = cur_byte[bit_q];

  always_comb begin
    if (cur_bit) begin
      len_sel = high_q ? pulse_i.one_high : pulse_i.one_low;
    end else begin
      len_sel = high_q ? pulse_i.zero_high : pulse_i.zero_low;
    end
  end

  assign len     = (len_sel == 8'd0) ? 8'd1 : len_sel;
  assign cnt_inc = cnt_q + 8'd1;

  always_comb begin
    sending_d = sending_q;
    high_d    = high_q;
    cnt_d     = cnt_q;
    bit_d     = bit_q;
    lane_d    = lane_q;
    pix_d     = pix_q;
    status    = ST_OK;
    if (accept_i) begin
      case (req_i)
        REQ_SET: begin
          if (!idx_ok_i) begin
            status = ST_BAD_INDEX;
          end
        end
        REQ_CLEAR: begin
          status = ST_OK;
        end
        REQ_SHOW: begin
          if (sending_q) begin
            status = ST_BUSY;
          end else begin
            sending_d = 1'b1;
            high_d    = 1'b1;
            cnt_d     = 8'd0;
            bit_d     = 3'd7;
            lane_d    = 2'd0;
            pix_d     = '0;
          end
        end
        REQ_TICK: begin
          if (sending_q) begin
            if (cnt_inc < len) begin
              cnt_d = cnt_inc;
            end else begin
              cnt_d = 8'd0;
              if (high_q) begin
                high_d = 1'b0;
              end else begin
                high_d = 1'b1;
                if (bit_q == 3'd0) begin
                  bit_d = 3'd7;
                  if (lane_q == 2'd3) begin
                    lane_d = 2'd0;
                    if (pix_q == IW'(LED_COUNT - 1)) begin
                      // last bit of the frame
                      pix_d     = '0;
                      sending_d = 1'b0;
                      high_d    = 1'b0;
                    end else begin
                      pix_d = pix_q + IW'(1);
                    end
                  end else begin
                    lane_d = lane_q + 2'd1;
                  end
                end else begin
                  bit_d = bit_q - 3'd1;
                end
              end
            end
          end
        end
        default: begin
          status = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q <= 1'b0;
      high_q    <= 1'b0;
      cnt_q     <= 8'd0;
      bit_q     <= 3'd7;
      lane_q    <= 2'd0;
      pix_q     <= '0;
    end else begin
      sending_q <= sending_d;
      high_q    <= high_d;
      cnt_q     <= cnt_d;
      bit_q     <= bit_d;
      lane_q    <= lane_d;
      pix_q     <= pix_d;
    end
  end

  assign pix_o        = pix_q;
  assign pix_next_o   = pix_d;
  assign res_o.status = status;
  assign res_o.busy   = sending_d;
  assign res_o.level  = sending_d & high_d;

endmodule

>>> sv/rgbw_pixel_led_serializer_unit.sv
// rgbw_pixel_led_serializer_unit: top level of the rgbw pixel chain serializer
//
//  port group   dir  payload
//  s_axis_*     in   tuser: req_type; tdata: led_index, red_in, green_in, blue_in
//  m_axis_*     out  tdata: data_level, busy_res, status
//  cfg_*        in   register index and write data, no read-back
//
// One item per clock unless stalled; each gives one result in the next cycle.
// The pixel rows sit in a one-port-write memory read every cycle at the next
// pixel; a set is scaled (multiply, reciprocal) and forwarded to the serializer.
// Reset clears the valid bits of all rows at once; no clearing pass.
// A stall on the output holds the result; input is taken whenever the output
// register is empty or is being drained in the same cycle.
`timescale 1ns / 1ps

module rgbw_pixel_led_serializer_unit import rpls_pkg::*; #(
  parameter int LED_COUNT = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // led_index[3:0], red_in, green_in, blue_in, zero pad
  input  logic [1:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // data_level, busy_res, status[1:0], zero pad
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int IW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  logic          accept;
  req_e          req;
  logic [3:0]    led_index;
  logic          idx_ok;
  logic [6:0]    pct_q;
  pulse_cfg_t    pulse_q;
  logic          wr_vld;
  logic [IW-1:0] wr_idx;
  logic [23:0]   wr_data;
  logic [23:0]   store_row, row_eff;
  logic [IW-1:0] pix, pix_next;
  result_t       res;
  logic          out_vld_q;
  logic [7:0]    out_data_q;

  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign req           = req_e'(s_axis_tuser);
  assign led_index     = s_axis_tdata[3:0];
  assign idx_ok        = 7'(led_index) < 7'(LED_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_q             <= RST_BRIGHTNESS;
      pulse_q.zero_high <= RST_ZERO_HIGH;
      pulse_q.zero_low  <= RST_ZERO_LOW;
      pulse_q.one_high  <= RST_ONE_HIGH;
      pulse_q.one_low   <= RST_ONE_LOW;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BRIGHTNESS: pct_q             <= cfg_data_i[6:0];
        CFG_ZERO_HIGH:  pulse_q.zero_high <= cfg_data_i;
        CFG_ZERO_LOW:   pulse_q.zero_low  <= cfg_data_i;
        CFG_ONE_HIGH:   pulse_q.one_high  <= cfg_data_i;
        CFG_ONE_LOW:    pulse_q.one_low   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rpls_scale #(.LED_COUNT(LED_COUNT)) u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .set_i     (accept && (req == REQ_SET) && idx_ok),
    .pct_i     (pct_q),
    .idx_i     (IW'(led_index)),
    .red_i     (s_axis_tdata[11:4]),
    .green_i   (s_axis_tdata[19:12]),
    .blue_i    (s_axis_tdata[27:20]),
    .wr_vld_o  (wr_vld),
    .wr_idx_o  (wr_idx),
    .wr_data_o (wr_data)
  );

  rpls_store #(.LED_COUNT(LED_COUNT)) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (accept && (req == REQ_CLEAR)),
    .wr_vld_i  (wr_vld),
    .wr_idx_i  (wr_idx),
    .wr_data_i (wr_data),
    .rd_addr_i (pix_next),
    .rd_row_o  (store_row)
  );

  // a set still in the scaler wins over the stored row
  assign row_eff = (wr_vld && (wr_idx == pix)) ? wr_data : store_row;

  rpls_ser #(.LED_COUNT(LED_COUNT)) u_ser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_i      (req),
    .idx_ok_i   (idx_ok),
    .pulse_i    (pulse_q),
    .row_i      (row_eff),
    .pix_o      (pix),
    .pix_next_o (pix_next),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (accept) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {4'b0000, res.status, res.busy, res.level};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> tb/rgbw_serializer_checker.sv
// rgbw_serializer_checker: tracks the led serializer state and checks every result item
`timescale 1ns / 1ps

module rgbw_serializer_checker import rpls_pkg::*; #(
  parameter int LED_COUNT = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [31:0] s_data_i,   // led_index[3:0], red_in, green_in, blue_in, zero pad
  input  logic [1:0]  s_user_i,   // req_type
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [7:0]  m_data_i,   // data_level, busy_res, status[1:0], zero pad
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  output int          mismatches_o,
  output int          pending_o,
  output logic        frame_busy_o
);

  localparam int STORE_BYTES = LED_COUNT * 4;

  // shadow of the pixel chain, stored as g, r, b, w bytes per led
  logic [7:0] pix_bytes [STORE_BYTES];
  int         byte_ptr;
  logic [2:0] bit_ptr;
  logic       high_phase;
  logic [7:0] phase_cnt;
  logic       sending;

  logic [6:0] bright;
  pulse_cfg_t pulses;

  result_t    line_results_q [$];
  result_t    want;
  result_t    got;

  function automatic logic [7:0] scale_color(logic [7:0] v);
    int pct;
    pct = (bright > PCT_FULL) ? int'(PCT_FULL) : int'(bright);
    return 8'((int'(v) * pct) / int'(PCT_FULL));
  endfunction

  function automatic logic [7:0] phase_ticks();
    logic [7:0] len;
    if (pix_bytes[byte_ptr][bit_ptr]) begin
      len = high_phase ? pulses.one_high : pulses.one_low;
    end else begin
      len = high_phase ? pulses.zero_high : pulses.zero_low;
    end
    // a zero length still takes one tick
    return (len == 8'd0) ? 8'd1 : len;
  endfunction

  function automatic void advance_tick();
    if (!sending) return;
    phase_cnt = phase_cnt + 8'd1;
    if (phase_cnt < phase_ticks()) return;
    phase_cnt = 8'd0;
    if (high_phase) begin
      high_phase = 1'b0;
      return;
    end
    high_phase = 1'b1;
    if (bit_ptr == 3'd0) begin
      bit_ptr = 3'd7;
      byte_ptr++;
      if (byte_ptr >= STORE_BYTES) begin
        byte_ptr   = 0;
        high_phase = 1'b0;
        sending    = 1'b0;
      end
    end else begin
      bit_ptr--;
    end
  endfunction

  function automatic result_t predict_line(req_e req, logic [3:0] idx, logic [7:0] red,
                                           logic [7:0] green, logic [7:0] blue);
    result_t r;
    r.status = ST_OK;
    case (req)
      REQ_SET: begin
        if (idx >= LED_COUNT) begin
          r.status = ST_BAD_INDEX;
        end else begin
          pix_bytes[idx * 4 + 0] = scale_color(green);
          pix_bytes[idx * 4 + 1] = scale_color(red);
          pix_bytes[idx * 4 + 2] = scale_color(blue);
          pix_bytes[idx * 4 + 3] = 8'd0;
        end
      end
      REQ_CLEAR: begin
        foreach (pix_bytes[i]) pix_bytes[i] = 8'd0;
      end
      REQ_SHOW: begin
        if (sending) begin
          r.status = ST_BUSY;
        end else begin
          sending    = 1'b1;
          byte_ptr   = 0;
          bit_ptr    = 3'd7;
          high_phase = 1'b1;
          phase_cnt  = 8'd0;
        end
      end
      default: advance_tick();
    endcase
    r.level = sending && high_phase;
    r.busy  = sending;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (pix_bytes[i]) pix_bytes[i] = 8'd0;
      byte_ptr         = 0;
      bit_ptr          = 3'd7;
      high_phase       = 1'b0;
      phase_cnt        = 8'd0;
      sending          = 1'b0;
      bright           = RST_BRIGHTNESS;
      pulses.zero_high = RST_ZERO_HIGH;
      pulses.zero_low  = RST_ZERO_LOW;
      pulses.one_high  = RST_ONE_HIGH;
      pulses.one_low   = RST_ONE_LOW;
      line_results_q.delete();
      mismatches_o     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BRIGHTNESS: bright           = cfg_data_i[6:0];
          CFG_ZERO_HIGH:  pulses.zero_high = cfg_data_i;
          CFG_ZERO_LOW:   pulses.zero_low  = cfg_data_i;
          CFG_ONE_HIGH:   pulses.one_high  = cfg_data_i;
          CFG_ONE_LOW:    pulses.one_low   = cfg_data_i;
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) begin
        line_results_q.push_back(predict_line(req_e'(s_user_i), s_data_i[3:0], s_data_i[11:4],
                                              s_data_i[19:12], s_data_i[27:20]));
      end
      if (m_valid_i && m_ready_i) begin
        if (line_results_q.size() == 0) begin
          $display("%0t: result item with none expected, expected none, actual %h",
                   $time, m_data_i);
          mismatches_o++;
        end else begin
          want = line_results_q.pop_front();
          got  = result_t'(m_data_i[3:0]);
          if (got.level !== want.level) begin
            $display("%0t: data_level expected %0d actual %0d", $time, want.level, got.level);
            mismatches_o++;
          end
          if (got.busy !== want.busy) begin
            $display("%0t: busy_res expected %0d actual %0d", $time, want.busy, got.busy);
            mismatches_o++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            mismatches_o++;
          end
        end
      end
    end
    pending_o    = line_results_q.size();
    frame_busy_o = sending;
  end

endmodule

>>> tb/tb_rgbw_pixel_led_serializer_unit.sv
// tb_rgbw_pixel_led_serializer_unit: stimulus, idling and verdict for the led serializer
`timescale 1ns / 1ps

module tb_rgbw_pixel_led_serializer_unit;
  import rpls_pkg::*;

  localparam int LED_COUNT   = 4;
  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASE_ITEMS = 157;
  localparam int RAND_PHASES = 9;
  // register indexes past the end of the list, which the block ignores
  localparam logic [2:0] CFG_SPARE_LO = 3'd5;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // led_index[3:0], red_in, green_in, blue_in, zero pad
  logic [1:0]  s_axis_tuser;   // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // data_level, busy_res, status[1:0], zero pad
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [7:0]  cfg_data_i;

  int   mismatches;
  int   pending;
  logic frame_busy;
  bit   gap_en;
  bit   stall_en;
  int   idle_cycles;

  rgbw_pixel_led_serializer_unit #(.LED_COUNT(LED_COUNT)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  rgbw_serializer_checker #(.LED_COUNT(LED_COUNT)) frame_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_user_i     (s_axis_tuser),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .frame_busy_o (frame_busy)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // random stalls on the output while stall_en is set
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i
          || !rst_ni) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("rgbw_pixel_led_serializer_unit test failed");
    $finish;
  end

  task automatic send_item(req_e req, logic [3:0] idx, logic [7:0] red, logic [7:0] green,
                           logic [7:0] blue);
    if (gap_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, blue, green, red, idx};
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_tick();
    send_item(REQ_TICK, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  function automatic logic [7:0] rand_color();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly short pulses so frames can end within the random part
  function automatic logic [7:0] rand_ticks();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'($urandom_range(5, 20));
      default: return 8'($urandom_range(1, 2));
    endcase
  endfunction

  task automatic send_random_item();
    int unsigned pick;
    logic [3:0]  idx;
    pick = $urandom_range(0, 99);
    idx  = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, LED_COUNT - 1)) : 4'($urandom);
    if (pick < 62) begin
      send_tick();
    end else if (pick < 84) begin
      send_item(REQ_SET, idx, rand_color(), rand_color(), rand_color());
    end else if (pick < 93) begin
      send_item(REQ_SHOW, idx, rand_color(), rand_color(), rand_color());
    end else begin
      send_item(REQ_CLEAR, idx, rand_color(), rand_color(), rand_color());
    end
  endtask

  // let every result drain before touching registers
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // tick until the frame in flight has gone out
  task automatic finish_frame();
    while (frame_busy) send_tick();
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
  endtask

  task automatic program_regs(logic [6:0] bright, logic [7:0] zero_hi, logic [7:0] zero_lo,
                              logic [7:0] one_hi, logic [7:0] one_lo);
    write_reg(CFG_BRIGHTNESS, {1'b0, bright});
    write_reg(CFG_ZERO_HIGH, zero_hi);
    write_reg(CFG_ZERO_LOW, zero_lo);
    write_reg(CFG_ONE_HIGH, one_hi);
    write_reg(CFG_ONE_LOW, one_lo);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [6:0] bright;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_SET;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    gap_en        = 1'b1;
    stall_en      = 1'b1;
    rst_ni        = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: idle tick, range edges, show, show while busy, writes during a frame
    send_item(REQ_TICK, 4'd9, 8'hFF, 8'h00, 8'hA5);
    send_item(REQ_SET, 4'd0, 8'hFF, 8'hFF, 8'hFF);
    send_item(REQ_SET, 4'd3, 8'h00, 8'h00, 8'h00);
    send_item(REQ_SET, 4'd4, 8'h12, 8'h34, 8'h56);
    send_item(REQ_SET, 4'd15, 8'hFF, 8'hFF, 8'hFF);
    send_item(REQ_SET, 4'd1, 8'hAA, 8'h55, 8'h01);
    send_item(REQ_SET, 4'd2, 8'h80, 8'hFE, 8'h7F);
    send_item(REQ_SHOW, 4'd0, 8'h00, 8'h00, 8'h00);
    send_item(REQ_SHOW, 4'd7, 8'hFF, 8'hFF, 8'hFF);
    repeat (6) send_tick();
    send_item(REQ_SET, 4'd1, 8'h00, 8'hFF, 8'h33);
    repeat (4) send_tick();
    send_item(REQ_CLEAR, 4'd0, 8'h00, 8'h00, 8'h00);
    repeat (3) send_tick();
    send_item(REQ_SHOW, 4'd0, 8'h00, 8'h00, 8'h00);
    settle();

    // brightness above full scale, zero pulse lengths, writes past the register list
    write_reg(CFG_SPARE_LO, 8'hFF);
    write_reg(CFG_SPARE_HI, 8'h01);
    program_regs(7'd127, 8'd0, 8'd0, 8'd0, 8'd0);
    finish_frame();
    send_item(REQ_SET, 4'd0, 8'hFF, 8'hFF, 8'hFF);
    send_item(REQ_SET, 4'd2, 8'h01, 8'h80, 8'h64);
    send_item(REQ_SHOW, 4'd0, 8'h00, 8'h00, 8'h00);
    finish_frame();
    settle();

    // longest pulses, start of a frame that goes on under the random settings
    program_regs(7'd100, 8'd255, 8'd255, 8'd255, 8'd255);
    send_item(REQ_SET, 4'd3, 8'hC3, 8'h3C, 8'hFF);
    send_item(REQ_SHOW, 4'd0, 8'h00, 8'h00, 8'h00);

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      gap_en   = (p != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
      stall_en = (p != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
      case (p)
        0:       bright = 7'd0;
        1:       bright = 7'd100;
        2:       bright = 7'd101;
        default: bright = 7'($urandom_range(0, 127));
      endcase
      program_regs(bright, rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks());
      // fill the chain and ask for a frame, then mix ticks with other requests
      for (int led = 0; led < LED_COUNT; led++) begin
        send_item(REQ_SET, 4'(led), rand_color(), rand_color(), rand_color());
      end
      send_item(REQ_SHOW, 4'($urandom), rand_color(), rand_color(), rand_color());
      for (int n = LED_COUNT + 1; n < PHASE_ITEMS; n++) send_random_item();
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("rgbw_pixel_led_serializer_unit test passed");
    end else begin
      $display("rgbw_pixel_led_serializer_unit test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/rpls_pkg.sv
sv/rpls_scale.sv
sv/rpls_store.sv
sv/rpls_ser.sv
sv/rgbw_pixel_led_serializer_unit.sv
tb/rgbw_serializer_checker.sv
tb/tb_rgbw_pixel_led_serializer_unit.sv
